@@ hdl/rrda_pkg.sv @@
// Shared definitions for the round-robin disk allocator.
// Holds field widths, command, status and register codes, and the
// command and status structs between the controller and the datapath.
package rrda_pkg;

  // Field widths of the stream beats
  localparam int CMD_W      = 3;
  localparam int TSLOT_W    = 4;
  localparam int FREE_W     = 63;
  localparam int LABEL_W    = 6;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 4;
  localparam int COUNT_W    = 5;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 72;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;
  localparam int TIER_W     = 2;

  // Register decode uses address bit 3 (registers sit 8 bytes apart)
  localparam logic REG_MIN_FREE = 1'b0;
  localparam logic REG_TIER     = 1'b1;

  localparam logic [FREE_W-1:0] MIN_FREE_RESET = 63'd52428800;
  localparam logic [FREE_W-1:0] FREE_MAX       = {FREE_W{1'b1}};
  localparam logic [TIER_W-1:0] TIER_RESERVED  = 2'd0;

  // Commands
  localparam logic [CMD_W-1:0] CMD_MOUNT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REPORT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PICK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_TARGET = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic exec;
    logic scan_run;
    logic label_use;
    logic probe_run;
    logic out_load;
  } rrda_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_done;
    logic is_scan;
    logic is_alloc;
    logic alloc_none;
    logic scan_done;
    logic probe_hit;
    logic probe_miss;
    logic out_busy;
  } rrda_sts_t;

endpackage

@@ hdl/rrda_ctrl.sv @@
// Sequencing state machine of the round-robin disk allocator.
// Depends on rrda_pkg for the command and status structs.
module rrda_ctrl import rrda_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  rrda_sts_t sts,
  output rrda_ctl_t ctl
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_LABEL = 7'b0010000,
    S_PROBE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.is_scan) begin
          state_next = S_SCAN;
        end else if (sts.is_alloc && !sts.alloc_none) begin
          state_next = S_LABEL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        ctl.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_LABEL: begin
        ctl.label_use = 1'b1;
        state_next    = S_PROBE;
      end
      S_PROBE: begin
        ctl.probe_run = 1'b1;
        if (sts.probe_hit || sts.probe_miss) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

@@ hdl/rrda_datapath.sv @@
// Datapath of the round-robin disk allocator: target table, free-bytes
// memory, label cursor memory, scan and probe engine and output register.
// Depends on rrda_pkg; driven by rrda_ctrl through the command struct.
module rrda_datapath import rrda_pkg::*; #(
  parameter int MAX_TARGETS = 16,
  parameter int NUM_LABELS  = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rrda_ctl_t             ctl,
  output rrda_sts_t             sts,
  input  logic [FREE_W-1:0]     min_free_bytes,
  input  logic [TIER_W-1:0]     tier_level,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [TSLOT_W-1:0]    in_target_slot,
  input  logic                  in_is_primary,
  input  logic                  in_is_disabled,
  input  logic [FREE_W-1:0]     in_free_bytes,
  input  logic [LABEL_W-1:0]    in_label_index,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SLOT_OUT_W-1:0] out_slot,
  output logic [FREE_W-1:0]     out_sum,
  output logic [COUNT_W-1:0]    out_count
);

  localparam int SLOT_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
  localparam int LAB_W  = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
  localparam int LABEL_VALUES = 2 ** LABEL_W;
  localparam int LENT_W = SLOT_W + 1;
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_TARGETS);
  localparam logic [LAB_W-1:0] LAB_LAST = LAB_W'(NUM_LABELS - 1);

  // Captured item
  logic [CMD_W-1:0]   cmd_q;
  logic [TSLOT_W-1:0] tslot_q;
  logic               prim_q;
  logic               dis_q;
  logic [FREE_W-1:0]  fb_q;
  logic [LAB_W-1:0]   lab_q;

  // Target table and counters
  logic [MAX_TARGETS-1:0] slot_present;
  logic [MAX_TARGETS-1:0] slot_disabled;
  logic [MAX_TARGETS-1:0] free_valid;
  logic [FREE_W-1:0]      fmem [MAX_TARGETS];
  logic [CNT_W-1:0]       mounted_count;
  logic [CNT_W-1:0]       enabled_targets;
  logic [SLOT_W-1:0]      start_cursor;

  // Label cursor memory, entries hold {valid, cursor}
  logic [LENT_W-1:0] lmem [NUM_LABELS];
  logic [LENT_W-1:0] lrd_q;
  logic [LAB_W-1:0]  clr_addr;
  logic              lw_en;
  logic [LENT_W-1:0] lw_data;

  // Scan and probe engine
  logic [CNT_W-1:0]  iss_cnt;
  logic [CNT_W-1:0]  iss_lim;
  logic [SLOT_W-1:0] pd;
  logic [CNT_W-1:0]  pd_inc;
  logic [SLOT_W-1:0] raddr;
  logic              issue;
  logic              rvld_q;
  logic [SLOT_W-1:0] ridx_q;
  logic [FREE_W-1:0] rd_q;
  logic              fval_q;
  logic [FREE_W-1:0] rfree;
  logic              rpres;
  logic              rdis;
  logic [CNT_W-1:0]  rnext_inc;
  logic [SLOT_W-1:0] rnext;
  logic [SLOT_W-1:0] best_idx;
  logic [FREE_W-1:0] best_free;
  logic [FREE_W:0]   sum_wide;

  // Results
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [FREE_W-1:0]   res_sum;
  logic [CNT_W-1:0]    res_cnt;

  // Decoded operations
  logic              is_mount, is_report, is_refresh, is_pick, is_alloc;
  logic [CNT_W:0]    id_wide;
  logic [SLOT_W-1:0] id_slot;
  logic              mount_err;
  logic              mount_we;
  logic              rep_we;
  logic              usable;
  logic              refresh_act;
  logic              pick_act;
  logic              scan_fin;
  logic [LENT_W-1:0] cur_entry;

  // Label index folded onto the label range by a constant table
  logic [LAB_W-1:0] lab_map [LABEL_VALUES];
  for (genvar g = 0; g < LABEL_VALUES; g++) begin : g_lab_map
    assign lab_map[g] = LAB_W'(g % NUM_LABELS);
  end

  assign is_mount   = (cmd_q == CMD_MOUNT);
  assign is_report  = (cmd_q == CMD_REPORT);
  assign is_refresh = (cmd_q == CMD_REFRESH);
  assign is_pick    = (cmd_q == CMD_PICK);
  assign is_alloc   = (cmd_q == CMD_ALLOC);

  function automatic logic [CNT_W:0] in_prim_sel(input logic prim,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W:0] r;
    r = prim ? '0 : ({1'b0, n} + (CNT_W + 1)'(1));
    return r;
  endfunction

  // Mount slot choice: slot zero is held back for the primary at level zero
  always_comb begin
    if (tier_level == TIER_RESERVED && !slot_present[0]) begin
      id_wide = in_prim_sel(prim_q, mounted_count);
    end else begin
      id_wide = {1'b0, mounted_count};
    end
    mount_err = (mounted_count >= MAX_CNT) || (id_wide >= (CNT_W + 1)'(MAX_TARGETS));
    id_slot   = SLOT_W'(id_wide);
  end

  assign mount_we = ctl.exec && is_mount && !mount_err;
  assign rep_we   = ctl.exec && is_report && (32'(tslot_q) < 32'(MAX_TARGETS));

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= in_cmd;
      tslot_q <= in_target_slot;
      prim_q  <= in_is_primary;
      dis_q   <= in_is_disabled;
      fb_q    <= in_free_bytes;
      lab_q   <= lab_map[in_label_index];
    end
  end

  // Present, disabled and free-valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_present  <= '0;
      slot_disabled <= '0;
      free_valid    <= '0;
      mounted_count <= '0;
    end else begin
      if (mount_we) begin
        slot_present[id_slot]  <= 1'b1;
        slot_disabled[id_slot] <= dis_q;
        free_valid[id_slot]    <= 1'b0;
        mounted_count          <= mounted_count + CNT_W'(1);
      end else if (rep_we) begin
        free_valid[SLOT_W'(tslot_q)] <= 1'b1;
      end
    end
  end

  // Issue side of the scan and probe engine
  assign iss_lim = is_alloc ? MAX_CNT : mounted_count;
  assign issue   = (ctl.scan_run || ctl.probe_run) && (iss_cnt != iss_lim);
  assign raddr   = ctl.probe_run ? pd : SLOT_W'(iss_cnt);
  assign pd_inc  = CNT_W'(pd) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rvld_q  <= 1'b0;
      iss_cnt <= '0;
    end else begin
      rvld_q <= issue;
      if (ctl.exec || ctl.label_use) begin
        iss_cnt <= '0;
      end else if (issue) begin
        iss_cnt <= iss_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.label_use) begin
      pd <= cur_entry[SLOT_W-1:0];
    end else if (ctl.probe_run && issue) begin
      pd <= (pd_inc == mounted_count) ? '0 : SLOT_W'(pd_inc);
    end
  end

  // Free-bytes memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (rep_we) begin
      fmem[SLOT_W'(tslot_q)] <= fb_q;
    end
    rd_q   <= fmem[raddr];
    fval_q <= free_valid[raddr];
    ridx_q <= raddr;
  end

  // Read stage: a never-reported or remounted slot reads as zero
  assign rfree     = fval_q ? rd_q : '0;
  assign rpres     = slot_present[ridx_q];
  assign rdis      = slot_disabled[ridx_q];
  assign usable    = rpres && !rdis && !(rfree < min_free_bytes);
  assign rnext_inc = CNT_W'(ridx_q) + CNT_W'(1);
  assign rnext     = (rnext_inc == mounted_count) ? '0 : SLOT_W'(rnext_inc);
  assign sum_wide  = {1'b0, res_sum} + {1'b0, rfree};

  assign refresh_act = ctl.scan_run && rvld_q && is_refresh;
  assign pick_act    = ctl.scan_run && rvld_q && is_pick;
  assign scan_fin    = (iss_cnt == iss_lim) && !rvld_q;

  // Label entry in use: a fresh label starts at the start cursor
  assign cur_entry = lrd_q[SLOT_W] ? lrd_q : {1'b1, start_cursor};

  // Label memory writes: clearing pass, first use of a label, cursor advance
  always_comb begin
    lw_en   = 1'b0;
    lw_data = cur_entry;
    if (ctl.label_use && !lrd_q[SLOT_W]) begin
      lw_en = 1'b1;
    end else if (sts.probe_hit) begin
      lw_en   = 1'b1;
      lw_data = {1'b1, rnext};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear_step) begin
      lmem[clr_addr] <= '0;
    end else if (lw_en) begin
      lmem[lab_q] <= lw_data;
    end
    lrd_q <= lmem[lab_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear_step && clr_addr != LAB_LAST) begin
      clr_addr <= clr_addr + LAB_W'(1);
    end
  end

  // Best-target search for the start cursor
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      best_idx  <= '0;
      best_free <= '0;
    end else if (pick_act) begin
      if (ridx_q == '0) begin
        best_free <= rpres ? rfree : '0;
      end else if (rpres && rfree > min_free_bytes && rfree > best_free) begin
        best_idx  <= ridx_q;
        best_free <= rfree;
      end
    end
  end

  // Totals and cursors kept across items
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_targets <= '0;
      start_cursor    <= '0;
    end else if (ctl.scan_run && scan_fin) begin
      if (is_refresh) begin
        enabled_targets <= res_cnt;
      end
      if (is_pick) begin
        start_cursor <= best_idx;
      end
    end
  end

  // Result fields of the item at work
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_status <= ST_OK;
      res_slot   <= '0;
      res_sum    <= '0;
      res_cnt    <= '0;
    end else if (ctl.exec) begin
      if (is_mount) begin
        res_status <= mount_err ? ST_TOO_MANY : ST_OK;
        res_slot   <= mount_err ? '0 : id_slot;
      end else if (is_alloc && sts.alloc_none) begin
        res_status <= ST_NO_TARGET;
      end
    end else if (refresh_act) begin
      if (rpres) begin
        res_sum <= sum_wide[FREE_W] ? FREE_MAX : sum_wide[FREE_W-1:0];
        if (!rdis) begin
          res_cnt <= res_cnt + CNT_W'(1);
        end
      end
    end else if (sts.probe_hit) begin
      res_slot <= ridx_q;
    end else if (sts.probe_miss) begin
      res_status <= ST_NO_TARGET;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status <= res_status;
      out_slot   <= SLOT_OUT_W'(res_slot);
      out_sum    <= res_sum;
      out_count  <= COUNT_W'(res_cnt);
    end
  end

  // Status towards the controller
  always_comb begin
    sts            = '0;
    sts.clear_done = (clr_addr == LAB_LAST);
    sts.is_scan    = is_refresh || is_pick;
    sts.is_alloc   = is_alloc;
    sts.alloc_none = (mounted_count == '0) || (enabled_targets == '0);
    sts.scan_done  = scan_fin;
    sts.probe_hit  = ctl.probe_run && rvld_q && usable;
    sts.probe_miss = ctl.probe_run && (iss_cnt == MAX_CNT) && !rvld_q;
    sts.out_busy   = out_valid && !out_ready;
  end

endmodule

@@ hdl/round_robin_disk_allocator_unit.sv @@
// Round-robin disk allocator, top level: stream ports, configuration
// registers and the controller and datapath instances.
// Depends on rrda_pkg, rrda_ctrl and rrda_datapath.
//
// One command beat gives exactly one result beat. After reset the block
// first clears its label cursor memory, one entry a cycle, and s_tready
// stays low until it is done (register writes are taken throughout).
// Mount, report and unknown commands, and an allocation that finds no
// mounted or no enabled target, go from the execute state straight to the
// done state. Refresh and pick-start walk as many slots as are mounted,
// from slot zero up, through the single read port of the free-bytes
// memory, one slot a cycle. Any other allocation reads the label cursor
// memory and then probes up to MAX_TARGETS slots one a cycle through the
// same port. One command is worked at a time; the next command is taken
// in the cycle after a result enters the output register, and its own
// result is held back until that register is free.
module round_robin_disk_allocator_unit import rrda_pkg::*; #(
  parameter int MAX_TARGETS = 16,
  parameter int NUM_LABELS  = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // Command stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // target_slot[3:0], is_primary[4], is_disabled[5], free_bytes[68:6],
  // label_index[74:69], zero padding[79:75]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd[2:0]
  input  logic [CMD_W-1:0]      s_tuser,
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // slot_out[3:0], tier_free_bytes[66:4], enabled_count[71:67]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [STATUS_W-1:0]   m_tuser,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [FREE_W-1:0]     min_free_bytes;
  logic [TIER_W-1:0]     tier_level;
  logic                  cfg_we;
  rrda_ctl_t             ctl;
  rrda_sts_t             sts;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [FREE_W-1:0]     out_sum;
  logic [COUNT_W-1:0]    out_count;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_free_bytes <= MIN_FREE_RESET;
      tier_level     <= '0;
    end else if (cfg_we) begin
      if (paddr[3] == REG_MIN_FREE) begin
        min_free_bytes <= pwdata[FREE_W-1:0];
      end else begin
        tier_level <= pwdata[TIER_W-1:0];
      end
    end
  end

  assign prdata = (paddr[3] == REG_TIER) ? APB_DATA_W'(tier_level)
                                         : APB_DATA_W'(min_free_bytes);

  // Sequencer
  rrda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Tables, memories and result path
  rrda_datapath #(
    .MAX_TARGETS (MAX_TARGETS),
    .NUM_LABELS  (NUM_LABELS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .min_free_bytes (min_free_bytes),
    .tier_level     (tier_level),
    .in_cmd         (s_tuser),
    .in_target_slot (s_tdata[3:0]),
    .in_is_primary  (s_tdata[4]),
    .in_is_disabled (s_tdata[5]),
    .in_free_bytes  (s_tdata[68:6]),
    .in_label_index (s_tdata[74:69]),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .out_status     (m_tuser),
    .out_slot       (out_slot),
    .out_sum        (out_sum),
    .out_count      (out_count)
  );

  assign m_tdata = {out_count, out_sum, out_slot};

endmodule
